// ----- rtl/tovm_pkg.sv -----
// Shared types and constants for the three-operand instruction executor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tovm_pkg;

    typedef enum logic [4:0] {
        OP_HALT = 5'd0, OP_JZ = 5'd1, OP_JNZ = 5'd2, OP_JMP = 5'd3, OP_PRINT = 5'd4,
        OP_MOV = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_MUL = 5'd8, OP_DIV = 5'd9,
        OP_MOD = 5'd10, OP_LAND = 5'd11, OP_LOR = 5'd12, OP_LNOT = 5'd13, OP_CG = 5'd14,
        OP_CL = 5'd15, OP_CGE = 5'd16, OP_CLE = 5'd17, OP_CE = 5'd18, OP_CNE = 5'd19
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_RDA, ST_RDB, ST_RDC, ST_EXEC, ST_MUL, ST_DIV, ST_WRITE, ST_OUT
    } state_t;

    localparam int STORE_DEPTH = 256;

    localparam int IN_BITS  = 167;
    localparam int IN_BYTES = 168;
    localparam int OUT_BITS = 147;
    localparam int OUT_BYTES = 152;

endpackage
`default_nettype wire

// ----- rtl/three_operand_vm_execute.sv -----
// Top level of the three-operand instruction executor: word store, sequencer and
// a shared multiply and divide unit. Depends on tovm_pkg.
// Throughput: one item at a time; the next is taken the cycle after the result beat.
// The multiply takes 16 bits of the second operand a cycle; divide one bit a cycle.
// After reset a clearing pass zeroes the store; no item is accepted meanwhile. The
// program counter reloads from cfg_wdata on each cfg_we write.
`timescale 1ns / 1ps
`default_nettype none
module three_operand_vm_execute #(
    parameter int PC_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic s_tvalid,
    output logic s_tready,
    // op, mode, dst_addr, src1, src2, cond_addr, target, zero pad
    input  wire logic [tovm_pkg::IN_BYTES-1:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // next_pc, halted, print_valid, print_value, wrote, written_value, zero pad
    output logic [tovm_pkg::OUT_BYTES-1:0] m_tdata
);
    import tovm_pkg::*;
    localparam int AW = $clog2(STORE_DEPTH);

    logic [63:0] mem [STORE_DEPTH];
    logic [63:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic mem_we;
    logic [AW-1:0] waddr;
    logic [63:0] wdata;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic stop_reg, stop_next;
    logic [4:0] op_reg;
    logic [1:0] mode_reg;
    logic [7:0] dst_reg, cnd_reg;
    logic [15:0] tgt_reg;
    logic [63:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [63:0] acc_reg, acc_next, q_reg, q_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [15:0] npc_reg, npc_next;
    logic pv_reg, pv_next, wr_reg, wr_next;
    logic [63:0] pval_reg, pval_next, res_reg, res_next;
    logic [64:0] rem_sh;
    logic [63:0] rem_sub;
    logic [79:0] part;
    logic take;

    assign take = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {5'd0, res_reg, wr_reg, pval_reg, pv_reg, stop_reg, npc_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= s_tdata[4:0];
            mode_reg <= s_tdata[6:5];
            dst_reg <= s_tdata[14:7];
            a_reg <= s_tdata[78:15];
            b_reg <= s_tdata[142:79];
            cnd_reg <= s_tdata[150:143];
            tgt_reg <= s_tdata[166:151];
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        c_reg <= c_next;
        acc_reg <= acc_next;
        q_reg <= q_next;
        cnt_reg <= cnt_next;
        npc_reg <= npc_next;
        pv_reg <= pv_next;
        wr_reg <= wr_next;
        pval_reg <= pval_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            pc_reg <= '0;
            stop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            pc_reg <= cfg_we ? PC_WIDTH'({16'd0, cfg_wdata}) : pc_next;
            stop_reg <= stop_next;
        end
    end

    always_comb
    begin
        rem_sh = {acc_reg, q_reg[63]};
        rem_sub = rem_sh[63:0] - b_reg;
        part = 80'(a_reg) * 80'(b_reg[15:0]);
    end

    always_comb
    begin
        logic [PC_WIDTH-1:0] inc, npc_w;
        logic signed [63:0] sa, sb;
        inc = pc_reg + 1'b1;
        npc_w = inc;
        sa = a_reg;
        sb = b_reg;
        state_next = state_reg;
        clr_next = clr_reg;
        pc_next = pc_reg;
        stop_next = stop_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        acc_next = acc_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        npc_next = npc_reg;
        pv_next = pv_reg;
        wr_next = wr_reg;
        pval_next = pval_reg;
        res_next = res_reg;
        mem_we = 1'b0;
        waddr = clr_reg;
        wdata = '0;
        raddr = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    raddr = s_tdata[15 +: AW];
                    state_next = ST_RDA;
                end
            end
            ST_RDA:
            begin
                raddr = b_reg[AW-1:0];
                if (!mode_reg[1])
                begin
                    a_next = rdata_reg;
                end
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                raddr = cnd_reg[AW-1:0];
                if (!mode_reg[0])
                begin
                    b_next = rdata_reg;
                end
                state_next = ST_RDC;
            end
            ST_RDC:
            begin
                c_next = rdata_reg;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                pv_next = 1'b0;
                pval_next = '0;
                wr_next = 1'b1;
                res_next = '0;
                state_next = ST_WRITE;
                if (stop_reg)
                begin
                    npc_w = pc_reg;
                    wr_next = 1'b0;
                end
                else
                begin
                    case (op_reg) inside
                        OP_HALT:
                        begin
                            stop_next = 1'b1;
                            npc_w = pc_reg;
                            wr_next = 1'b0;
                        end
                        OP_JZ:
                        begin
                            if (c_reg == '0) npc_w = PC_WIDTH'(tgt_reg);
                            wr_next = 1'b0;
                        end
                        OP_JNZ:
                        begin
                            if (c_reg != '0) npc_w = PC_WIDTH'(tgt_reg);
                            wr_next = 1'b0;
                        end
                        OP_JMP:
                        begin
                            npc_w = PC_WIDTH'(tgt_reg);
                            wr_next = 1'b0;
                        end
                        OP_PRINT:
                        begin
                            pv_next = 1'b1;
                            pval_next = c_reg;
                            wr_next = 1'b0;
                        end
                        OP_MOV:
                        begin
                            if (!mode_reg[0]) res_next = a_reg;
                            else wr_next = 1'b0;
                        end
                        OP_ADD: res_next = a_reg + b_reg;
                        OP_SUB: res_next = a_reg - b_reg;
                        OP_MUL:
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            state_next = ST_MUL;
                        end
                        OP_DIV, OP_MOD:
                        begin
                            if (b_reg == '0)
                            begin
                                res_next = (op_reg == OP_DIV) ? '1 : a_reg;
                            end
                            else
                            begin
                                acc_next = '0;
                                q_next = a_reg;
                                cnt_next = '0;
                                state_next = ST_DIV;
                            end
                        end
                        OP_LAND: res_next = 64'(a_reg != '0 && b_reg != '0);
                        OP_LOR: res_next = 64'(a_reg != '0 || b_reg != '0);
                        OP_LNOT: res_next = 64'(a_reg == '0);
                        OP_CG: res_next = 64'(sa > sb);
                        OP_CL: res_next = 64'(sa < sb);
                        OP_CGE: res_next = 64'(sa >= sb);
                        OP_CLE: res_next = 64'(sa <= sb);
                        OP_CE: res_next = 64'(a_reg == b_reg);
                        OP_CNE: res_next = 64'(a_reg != b_reg);
                        default: wr_next = 1'b0;
                    endcase
                    pc_next = npc_w;
                end
                npc_next = 16'(npc_w);
            end
            ST_MUL:
            begin
                acc_next = acc_reg + (part[63:0] << {cnt_reg[1:0], 4'd0});
                b_next = b_reg >> 16;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'd3)
                begin
                    res_next = acc_next;
                    state_next = ST_WRITE;
                end
            end
            ST_DIV:
            begin
                q_next = {q_reg[62:0], 1'b0};
                if (rem_sh >= {1'b0, b_reg})
                begin
                    acc_next = rem_sub;
                    q_next[0] = 1'b1;
                end
                else
                begin
                    acc_next = rem_sh[63:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'd63)
                begin
                    res_next = (op_reg == OP_DIV) ? q_next : acc_next;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (wr_reg)
                begin
                    mem_we = 1'b1;
                    waddr = dst_reg[AW-1:0];
                    wdata = res_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/tovm_checker.sv -----
// Port-level checks for the three-operand instruction executor, and their bind.
// Depends on tovm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tovm_props (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [tovm_pkg::OUT_BYTES-1:0] m_tdata
);
    import tovm_pkg::*;
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("ready while result pending");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("second beat accepted");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] && m_tdata[17] |-> 0) else $error("print while halted");
endmodule
bind three_operand_vm_execute tovm_props u_chk (.clk(clk), .rst_n(rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata));
`default_nettype wire
